// ===== rtl/tlb_page_table_translator_macros.svh =====
// Assertion macros used by the address translator top level.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TLBPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLBPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tlbpt_pkg.sv =====
// Shared constants, state encoding and control/status structs for the translator.
package tlbpt_pkg;

  localparam int TLB_ENTRIES  = 16;
  localparam int OFFSET_BITS  = 8;
  localparam int ADDR_BITS    = 16;
  localparam int PAGE_BITS    = ADDR_BITS - OFFSET_BITS;
  localparam int NUM_PAGES    = 1 << PAGE_BITS;
  localparam int TLB_IDX_BITS = $clog2(TLB_ENTRIES);
  localparam int FREE_BITS    = PAGE_BITS + 1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_WORK
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;      // latch request and start page table read
    logic fault_write;  // commit a new mapping to table and TLB
    logic load_out;     // load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic tlb_match;
    logic table_valid;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/tlb_page_table_translator.sv =====
// A request is captured together with its registered page table read; the result is
// then loaded into the output register with the TLB compare and any fault write-back.
// Requests are taken one at a time, hit, table hit or fault alike.
// A waiting result does not block the next request from being accepted; that
// request then holds in the lookup state until the output register drains.
// Reset (synchronous, active high) clears TLB and page table valid bits, the TLB
// insert pointer, the free frame counter and the output valid; no clearing pass.
`include "tlb_page_table_translator_macros.svh"

module tlb_page_table_translator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tlbpt_pkg::ADDR_BITS-1:0]   virt_addr,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tlbpt_pkg::ADDR_BITS-1:0]   phys_addr,
  output logic                              tlb_hit,
  output logic                              page_fault
);

  tlbpt_pkg::dp_cmd_t    cmd;
  tlbpt_pkg::dp_status_t dp_status;

  tlbpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (dp_status),
    .cmd      (cmd)
  );

  tlbpt_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (dp_status),
    .virt_addr  (virt_addr),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .phys_addr  (phys_addr),
    .tlb_hit    (tlb_hit),
    .page_fault (page_fault)
  );

  // A TLB hit never reports a fault
  `TLBPT_ASSERT_NOW(a_hit_no_fault, out_valid, !(tlb_hit && page_fault), "hit with fault")
  // After a request is accepted the block is busy for the lookup
  `TLBPT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no busy cycle")
  // A fault write-back happens only on a TLB and page table miss while the result is loaded
  `TLBPT_ASSERT_NOW(a_fault_on_miss, cmd.fault_write,
                    cmd.load_out && !dp_status.tlb_match && !dp_status.table_valid,
                    "fault write without miss")

endmodule

// ===== rtl/tlbpt_datapath.sv =====
// Translator datapath: TLB, page table memory, frame allocator and output register.
module tlbpt_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  tlbpt_pkg::dp_cmd_t                  cmd,
  output tlbpt_pkg::dp_status_t               status,
  input  logic [tlbpt_pkg::ADDR_BITS-1:0]     virt_addr,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [tlbpt_pkg::ADDR_BITS-1:0]     phys_addr,
  output logic                                tlb_hit,
  output logic                                page_fault
);

  // Latched request
  logic [tlbpt_pkg::PAGE_BITS-1:0]    page_q;
  logic [tlbpt_pkg::OFFSET_BITS-1:0]  offset_q;

  // TLB storage
  logic [tlbpt_pkg::PAGE_BITS-1:0]    tlb_tag   [tlbpt_pkg::TLB_ENTRIES];
  logic [tlbpt_pkg::PAGE_BITS-1:0]    tlb_frame [tlbpt_pkg::TLB_ENTRIES];
  logic [tlbpt_pkg::TLB_ENTRIES-1:0]  tlb_valid;
  logic [tlbpt_pkg::TLB_IDX_BITS-1:0] ins_ptr;

  // Page table
  logic [tlbpt_pkg::PAGE_BITS-1:0]    pt_mem [tlbpt_pkg::NUM_PAGES];
  logic [tlbpt_pkg::NUM_PAGES-1:0]    pt_valid;
  logic [tlbpt_pkg::PAGE_BITS-1:0]    pt_rd_frame;
  logic                               pt_rd_valid;

  logic [tlbpt_pkg::FREE_BITS-1:0]    alloc_count;

  logic [tlbpt_pkg::PAGE_BITS-1:0]    in_page;
  logic                               match;
  logic [tlbpt_pkg::TLB_IDX_BITS-1:0] match_idx;
  logic [tlbpt_pkg::PAGE_BITS-1:0]    new_frame;
  logic [tlbpt_pkg::PAGE_BITS-1:0]    frame;
  logic                               fault;

  assign in_page   = virt_addr[tlbpt_pkg::ADDR_BITS-1:tlbpt_pkg::OFFSET_BITS];
  assign new_frame = alloc_count[tlbpt_pkg::PAGE_BITS-1:0];

  // Parallel TLB compare, lowest matching slot wins
  always_comb begin
    match     = 1'b0;
    match_idx = '0;
    for (int i = tlbpt_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid[i] && (tlb_tag[i] == page_q)) begin
        match     = 1'b1;
        match_idx = tlbpt_pkg::TLB_IDX_BITS'(i);
      end
    end
  end

  // Frame select: TLB, then table, then newly allocated frame
  always_comb begin
    fault = !match && !pt_rd_valid;
    if (match) begin
      frame = tlb_frame[match_idx];
    end else if (pt_rd_valid) begin
      frame = pt_rd_frame;
    end else begin
      frame = new_frame;
    end
  end

  assign status.tlb_match   = match;
  assign status.table_valid = pt_rd_valid;
  assign status.out_free    = !out_valid || !out_stall;

  // Request latch and registered page table read
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_q      <= in_page;
      offset_q    <= virt_addr[tlbpt_pkg::OFFSET_BITS-1:0];
      pt_rd_frame <= pt_mem[in_page];
      pt_rd_valid <= pt_valid[in_page];
    end
  end

  // Page table frame memory write
  always_ff @(posedge clk) begin
    if (cmd.fault_write) begin
      pt_mem[page_q] <= new_frame;
    end
  end

  // TLB tag/frame write at the FIFO slot
  always_ff @(posedge clk) begin
    if (cmd.fault_write) begin
      tlb_tag[ins_ptr]   <= page_q;
      tlb_frame[ins_ptr] <= new_frame;
    end
  end

  // Valid bits, insert pointer and frame allocator
  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_valid   <= '0;
      pt_valid    <= '0;
      ins_ptr     <= '0;
      alloc_count <= '0;
    end else if (cmd.fault_write) begin
      tlb_valid[ins_ptr] <= 1'b1;
      pt_valid[page_q]   <= 1'b1;
      if (ins_ptr == tlbpt_pkg::TLB_IDX_BITS'(tlbpt_pkg::TLB_ENTRIES - 1)) begin
        ins_ptr <= '0;
      end else begin
        ins_ptr <= ins_ptr + 1'b1;
      end
      if (alloc_count < tlbpt_pkg::FREE_BITS'(tlbpt_pkg::NUM_PAGES)) begin
        alloc_count <= alloc_count + 1'b1;
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      phys_addr  <= {frame, offset_q};
      tlb_hit    <= match;
      page_fault <= fault;
    end
  end

endmodule

// ===== rtl/tlbpt_ctrl.sv =====
// Translator controller: request acceptance and lookup sequencing.
module tlbpt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  tlbpt_pkg::dp_status_t  status,
  output tlbpt_pkg::dp_cmd_t     cmd
);

  tlbpt_pkg::state_t state;
  tlbpt_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlbpt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next      = state;
    in_stall        = 1'b1;
    cmd.capture     = 1'b0;
    cmd.fault_write = 1'b0;
    cmd.load_out    = 1'b0;
    unique case (state)
      tlbpt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = tlbpt_pkg::ST_WORK;
        end
      end
      tlbpt_pkg::ST_WORK: begin
        // TLB compare and table data ready; finish once output slot is free
        if (status.out_free) begin
          cmd.load_out    = 1'b1;
          cmd.fault_write = !status.tlb_match && !status.table_valid;
          state_next      = tlbpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tlbpt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the TLB and page table address translator.
`timescale 1ns / 100ps

module tb;

  localparam int RANDOM_REQUESTS = 850;
  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int BACKUP_CYCLES   = 300;
  localparam int BACKUP_AT       = 400;

  // One translated address as it leaves the block
  typedef struct packed {
    logic [tlbpt_pkg::ADDR_BITS-1:0] phys;
    logic                            hit;
    logic                            fault;
  } xlate_t;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic [tlbpt_pkg::ADDR_BITS-1:0] virt_addr;
  logic                            out_valid;
  logic                            out_stall;
  logic [tlbpt_pkg::ADDR_BITS-1:0] phys_addr;
  logic                            tlb_hit;
  logic                            page_fault;

  tlb_page_table_translator uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .virt_addr  (virt_addr),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .phys_addr  (phys_addr),
    .tlb_hit    (tlb_hit),
    .page_fault (page_fault)
  );

  // Mirror of the translator state
  logic [tlbpt_pkg::PAGE_BITS-1:0] tlb_tag   [tlbpt_pkg::TLB_ENTRIES];
  logic [tlbpt_pkg::PAGE_BITS-1:0] tlb_frame [tlbpt_pkg::TLB_ENTRIES];
  logic                            tlb_valid [tlbpt_pkg::TLB_ENTRIES];
  int                              tlb_slot;
  logic [tlbpt_pkg::PAGE_BITS-1:0] pt_frame  [tlbpt_pkg::NUM_PAGES];
  logic                            pt_valid  [tlbpt_pkg::NUM_PAGES];
  logic [tlbpt_pkg::FREE_BITS-1:0] alloc_count;

  logic [tlbpt_pkg::ADDR_BITS-1:0] addr_queue [$];
  xlate_t                          expected_xlate [$];
  xlate_t                          want;
  int                              addr_total;
  int                              req_offered;
  int                              req_accepted;
  int                              err_count;
  int                              idle_cycles;

  // Stimulus-side bookkeeping of pages already requested
  bit                              touched [tlbpt_pkg::NUM_PAGES];
  int                              touched_pages [$];
  int                              recent_pages [$];

  // Handshake pacing state
  int                              send_gap;
  bit                              send_quiet;
  int                              hold_left;
  bit                              recv_quiet;
  bit                              backup_done;

  always #2 clk = ~clk;

  // Translate one address and update the mirrored TLB and page table
  function automatic xlate_t translate_address(input logic [tlbpt_pkg::ADDR_BITS-1:0] va);
    logic [tlbpt_pkg::PAGE_BITS-1:0] page;
    logic [tlbpt_pkg::PAGE_BITS-1:0] frame;
    xlate_t                          r;
    page  = va[tlbpt_pkg::ADDR_BITS-1:tlbpt_pkg::OFFSET_BITS];
    frame = '0;
    r     = '0;
    for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
      if (!r.hit && tlb_valid[i] && tlb_tag[i] == page) begin
        frame = tlb_frame[i];
        r.hit = 1'b1;
      end
    end
    if (!r.hit) begin
      if (pt_valid[page]) begin
        frame = pt_frame[page];
      end else begin
        // page fault: take the next free frame, fill the FIFO slot
        r.fault             = 1'b1;
        frame               = alloc_count[tlbpt_pkg::PAGE_BITS-1:0];
        pt_frame[page]      = frame;
        pt_valid[page]      = 1'b1;
        tlb_tag[tlb_slot]   = page;
        tlb_frame[tlb_slot] = frame;
        tlb_valid[tlb_slot] = 1'b1;
        tlb_slot            = (tlb_slot + 1) % tlbpt_pkg::TLB_ENTRIES;
        if (alloc_count < tlbpt_pkg::NUM_PAGES) alloc_count = alloc_count + 1'b1;
      end
    end
    r.phys = {frame, va[tlbpt_pkg::OFFSET_BITS-1:0]};
    return r;
  endfunction

  // Gap length: mostly short, a few long, none in a quiet stretch
  function automatic int idle_gap(input bit quiet);
    int r;
    r = $urandom_range(99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Queue one request and note its page for the random mix
  task automatic queue_request(input logic [tlbpt_pkg::ADDR_BITS-1:0] va);
    int page;
    page = va[tlbpt_pkg::ADDR_BITS-1:tlbpt_pkg::OFFSET_BITS];
    addr_queue.push_back(va);
    if (!touched[page]) begin
      touched[page] = 1'b1;
      touched_pages.push_back(page);
      recent_pages.push_back(page);
      if (recent_pages.size() > tlbpt_pkg::TLB_ENTRIES) void'(recent_pages.pop_front());
    end
  endtask

  // Request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_accepted == req_offered) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (addr_queue.size() > 0) begin
        in_valid  <= 1'b1;
        virt_addr <= addr_queue.pop_front();
        req_offered++;
        if ($urandom_range(63) == 0) send_quiet = !send_quiet;
        send_gap = idle_gap(send_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side stall, with one long backup to fill the block
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (!backup_done && req_accepted >= BACKUP_AT) begin
      backup_done = 1'b1;
      hold_left   = BACKUP_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(63) == 0) recv_quiet = !recv_quiet;
      hold_left = idle_gap(recv_quiet);
      out_stall <= (hold_left > 0);
      if (hold_left > 0) hold_left--;
    end
  end

  // Accept monitor, result checker and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_xlate.push_back(translate_address(virt_addr));
        req_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (expected_xlate.size() == 0) begin
          $error("result with no request pending: phys_addr %h", phys_addr);
          err_count++;
        end else begin
          want = expected_xlate.pop_front();
          if (phys_addr !== want.phys) begin
            $error("phys_addr: expected %h, got %h", want.phys, phys_addr);
            err_count++;
          end
          if (tlb_hit !== want.hit) begin
            $error("tlb_hit: expected %b, got %b", want.hit, tlb_hit);
            err_count++;
          end
          if (page_fault !== want.fault) begin
            $error("page_fault: expected %b, got %b", want.fault, page_fault);
            err_count++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tlb_page_table_translator regression: fail");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int fresh_list [tlbpt_pkg::NUM_PAGES];
    int fresh_idx;
    int j;
    int tmp;
    int r;
    int page;
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    out_stall   = 1'b0;
    virt_addr   = '0;
    req_offered = 0;
    req_accepted = 0;
    err_count   = 0;
    idle_cycles = 0;
    send_gap    = 0;
    send_quiet  = 1'b0;
    hold_left   = 0;
    recv_quiet  = 1'b0;
    backup_done = 1'b0;
    tlb_slot    = 0;
    alloc_count = '0;
    for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
      tlb_tag[i]   = '0;
      tlb_frame[i] = '0;
      tlb_valid[i] = 1'b0;
    end
    for (int i = 0; i < tlbpt_pkg::NUM_PAGES; i++) begin
      pt_frame[i] = '0;
      pt_valid[i] = 1'b0;
      touched[i]  = 1'b0;
    end

    // Directed: address extremes, hits, faults, then a TLB eviction
    queue_request(16'h0000);
    queue_request(16'h00FF);
    queue_request(16'hFFFF);
    queue_request(16'hFF00);
    queue_request(16'h8000);
    queue_request(16'h7FFF);
    for (int p = 1; p <= 13; p++) begin
      queue_request({p[tlbpt_pkg::PAGE_BITS-1:0], tlbpt_pkg::OFFSET_BITS'($urandom())});
    end
    // page 0 left the TLB: served from the page table
    queue_request(16'h0055);
    // page 255 still in the TLB
    queue_request(16'hFFAA);

    // Random: new pages in shuffled order, recent pages, older pages, noise
    for (int i = 0; i < tlbpt_pkg::NUM_PAGES; i++) fresh_list[i] = i;
    for (int i = tlbpt_pkg::NUM_PAGES - 1; i > 0; i--) begin
      j             = $urandom_range(i);
      tmp           = fresh_list[i];
      fresh_list[i] = fresh_list[j];
      fresh_list[j] = tmp;
    end
    fresh_idx = 0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      r = $urandom_range(99);
      while (fresh_idx < tlbpt_pkg::NUM_PAGES && touched[fresh_list[fresh_idx]]) fresh_idx++;
      if (r < 30 && fresh_idx < tlbpt_pkg::NUM_PAGES) page = fresh_list[fresh_idx];
      else if (r < 70) page = recent_pages[$urandom_range(recent_pages.size() - 1)];
      else if (r < 85) page = touched_pages[$urandom_range(touched_pages.size() - 1)];
      else page = $urandom_range(tlbpt_pkg::NUM_PAGES - 1);
      queue_request({page[tlbpt_pkg::PAGE_BITS-1:0], tlbpt_pkg::OFFSET_BITS'($urandom())});
    end
    addr_total = addr_queue.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (!(req_accepted == addr_total && expected_xlate.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tlb_page_table_translator regression: pass");
    end else begin
      $display("tlb_page_table_translator regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tlbpt_pkg.sv
rtl/tlbpt_datapath.sv
rtl/tlbpt_ctrl.sv
rtl/tlb_page_table_translator.sv
tb/tb.sv
